[hw/rtl/pid_speed_controller_assert.svh]
// Assertion macros shared by the speed controller RTL
`ifndef PID_SPEED_CONTROLLER_ASSERT_SVH
`define PID_SPEED_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define PIDSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidsc assertion failed");

`define PIDSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidsc assertion failed");

`else

`define PIDSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PIDSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/pidsc_pkg.sv]
// Types, widths and constants of the PID speed controller
package pidsc_pkg;

    localparam int ERR_W        = 32;
    localparam int LIM_W        = 31;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int PERIOD_W     = 16;

    localparam int DIV_W        = 48;
    localparam int DVS_W        = 16;
    localparam int DIV_STEP     = 4;

    localparam int MS_PER_S         = 1000;
    localparam int FIRST_DERIV_NUM  = 65536000;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_MS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_MAG    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE     = 3'd5;

    typedef enum logic [2:0] {
        MUL_EP,
        MUL_KP,
        MUL_KI,
        MUL_KD,
        MUL_KA
    } t_mul_sel;

    typedef struct packed {
        logic     load_item;
        logic     clear_state;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        logic     div_integ;
        logic     take_integ;
        logic     take_deriv;
        logic     sum_init;
        logic     sum_add;
        logic     save_kii;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

[hw/rtl/pidsc_if.sv]
// Step, result and configuration channel interfaces
interface pidsc_step_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   req_type;
    logic signed [pidsc_pkg::ERR_W-1:0]     err_value;
    logic        [pidsc_pkg::LIM_W-1:0]     out_limit;

    modport source (output valid, output req_type, output err_value, output out_limit,
                    input ready);
    modport sink   (input valid, input req_type, input err_value, input out_limit,
                    output ready);
endinterface

interface pidsc_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pidsc_pkg::ERR_W-1:0]     drive;
    logic                                   keep_going;

    modport source (output valid, output drive, output keep_going, input ready);
    modport sink   (input valid, input drive, input keep_going, output ready);
endinterface

interface pidsc_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [pidsc_pkg::CFG_ADDR_W-1:0]       addr;
    logic [pidsc_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[hw/rtl/pidsc_div.sv]
// Iterative unsigned divider, several quotient bits per cycle
`include "pid_speed_controller_assert.svh"

module pidsc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pidsc_pkg::DIV_W-1:0]     i_dividend,
    input  logic [pidsc_pkg::DVS_W-1:0]     i_divisor,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [pidsc_pkg::DIV_W-1:0]     o_quotient
);

    localparam int DIV_ITER = pidsc_pkg::DIV_W / pidsc_pkg::DIV_STEP;
    localparam int CNT_W    = $clog2(DIV_ITER + 1);

    logic [pidsc_pkg::DIV_W-1:0]    r_quo;
    logic [pidsc_pkg::DVS_W-1:0]    r_rem;
    logic [pidsc_pkg::DVS_W-1:0]    r_dvs;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [pidsc_pkg::DIV_W-1:0]    n_quo;
    logic [pidsc_pkg::DVS_W-1:0]    n_rem;
    logic [pidsc_pkg::DVS_W:0]      w_trial;

    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < pidsc_pkg::DIV_STEP; k++) begin
            w_trial = {n_rem, n_quo[pidsc_pkg::DIV_W-1]};
            n_quo   = {n_quo[pidsc_pkg::DIV_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                w_trial  = w_trial - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = w_trial[pidsc_pkg::DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `PIDSC_ASSERT_IMP(a_rem_below_divisor, i_clk, i_rst_n, r_busy, r_rem < r_dvs)

endmodule

[hw/rtl/pidsc_ctrl.sv]
// Sequencer for one control step of the PID speed controller
module pidsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step_valid,
    input  logic                i_step_clear,
    output logic                o_step_ready,
    input  pidsc_pkg::t_sts     i_sts,
    output pidsc_pkg::t_cmd     o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MEP   = 11'b000_0000_0010,
        ST_DIVI  = 11'b000_0000_0100,
        ST_WAITI = 11'b000_0000_1000,
        ST_DIVD  = 11'b000_0001_0000,
        ST_WAITD = 11'b000_0010_0000,
        ST_MKP   = 11'b000_0100_0000,
        ST_MKI   = 11'b000_1000_0000,
        ST_MKD   = 11'b001_0000_0000,
        ST_MKA   = 11'b010_0000_0000,
        ST_FIN   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_step_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_step_valid) begin
                    if (i_step_clear) begin
                        o_cmd.clear_state = 1'b1;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        n_state         = ST_MEP;
                    end
                end
            end
            ST_MEP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pidsc_pkg::MUL_EP;
                n_state       = ST_DIVI;
            end
            ST_DIVI: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_integ = 1'b1;
                n_state         = ST_WAITI;
            end
            ST_WAITI: begin
                if (i_sts.div_done) begin
                    o_cmd.take_integ = 1'b1;
                    n_state          = ST_DIVD;
                end
            end
            ST_DIVD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_WAITD;
            end
            ST_WAITD: begin
                if (i_sts.div_done) begin
                    o_cmd.take_deriv = 1'b1;
                    n_state          = ST_MKP;
                end
            end
            ST_MKP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pidsc_pkg::MUL_KP;
                n_state       = ST_MKI;
            end
            ST_MKI: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = pidsc_pkg::MUL_KI;
                o_cmd.sum_init = 1'b1;
                n_state        = ST_MKD;
            end
            ST_MKD: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = pidsc_pkg::MUL_KD;
                o_cmd.sum_add  = 1'b1;
                o_cmd.save_kii = 1'b1;
                n_state        = ST_MKA;
            end
            ST_MKA: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pidsc_pkg::MUL_KA;
                o_cmd.sum_add = 1'b1;
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/pidsc_dp.sv]
// Datapath: registers, shared multiplier, divider and output stage
`include "pid_speed_controller_assert.svh"

module pidsc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pidsc_pkg::t_cmd                     i_cmd,
    output pidsc_pkg::t_sts                     o_sts,
    input  logic                                i_cfg_valid,
    input  logic [pidsc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [pidsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic signed [pidsc_pkg::ERR_W-1:0]  i_err_value,
    input  logic [pidsc_pkg::LIM_W-1:0]         i_out_limit,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic signed [pidsc_pkg::ERR_W-1:0]  o_drive,
    output logic                                o_keep_going
);

    localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > SAT_MAX) begin
            return 32'sh7fff_ffff;
        end else if (v < SAT_MIN) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    logic signed [31:0]                 r_gain_prop;
    logic signed [31:0]                 r_gain_integ;
    logic signed [31:0]                 r_gain_deriv;
    logic [pidsc_pkg::PERIOD_W-1:0]     r_period;
    logic [30:0]                        r_min_mag;
    logic [30:0]                        r_settle;

    logic signed [31:0]                 r_acc;
    logic signed [31:0]                 r_last;
    logic                               r_first;

    logic signed [31:0]                 r_err;
    logic [pidsc_pkg::LIM_W-1:0]        r_limit;
    logic signed [63:0]                 r_prod;
    logic signed [31:0]                 r_integ;
    logic signed [31:0]                 r_deriv;
    logic                               r_neg;
    logic signed [49:0]                 r_sum;
    logic signed [47:0]                 r_kii;

    logic                               r_out_valid;
    logic signed [31:0]                 r_drive;
    logic                               r_keep;

    logic [pidsc_pkg::PERIOD_W-1:0]     w_per;
    logic signed [31:0]                 w_mul_a;
    logic signed [31:0]                 w_mul_b;
    logic signed [63:0]                 w_prod;
    logic signed [47:0]                 w_fl;

    logic [47:0]                        w_ep;
    logic signed [32:0]                 w_diff;
    logic signed [43:0]                 w_dx;
    logic signed [43:0]                 w_d1000;
    logic [43:0]                        w_d1000_mag;
    logic [pidsc_pkg::DIV_W-1:0]        w_dividend;
    logic [pidsc_pkg::DVS_W-1:0]        w_divisor;
    logic                               w_neg;
    logic                               w_div_busy;
    logic                               w_div_done;
    logic [pidsc_pkg::DIV_W-1:0]        w_quo;
    logic signed [49:0]                 w_qs;

    logic signed [31:0]                 w_u;
    logic signed [31:0]                 w_limp;
    logic signed [31:0]                 w_limn;
    logic signed [31:0]                 w_s;
    logic                               w_rev;
    logic signed [31:0]                 w_s2;
    logic signed [31:0]                 w_minp;
    logic signed [31:0]                 w_drive;
    logic [31:0]                        w_emag;
    logic                               w_keep;

    assign w_per = (r_period == '0) ? pidsc_pkg::PERIOD_W'(1) : r_period;

    always_comb begin
        case (i_cmd.mul_sel)
            pidsc_pkg::MUL_EP: begin
                w_mul_a = r_err;
                w_mul_b = signed'({16'd0, w_per});
            end
            pidsc_pkg::MUL_KP: begin
                w_mul_a = r_gain_prop;
                w_mul_b = r_err;
            end
            pidsc_pkg::MUL_KI: begin
                w_mul_a = r_gain_integ;
                w_mul_b = r_integ;
            end
            pidsc_pkg::MUL_KD: begin
                w_mul_a = r_gain_deriv;
                w_mul_b = r_deriv;
            end
            pidsc_pkg::MUL_KA: begin
                w_mul_a = r_gain_integ;
                w_mul_b = r_acc;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_fl   = r_prod[63:16];

    assign w_ep        = r_prod[47:0];
    assign w_diff      = 33'(r_err) - 33'(r_last);
    assign w_dx        = 44'(w_diff);
    assign w_d1000     = (w_dx <<< 10) - (w_dx <<< 4) - (w_dx <<< 3);
    assign w_d1000_mag = w_diff[32] ? 44'(-w_d1000) : 44'(w_d1000);

    always_comb begin
        if (i_cmd.div_integ) begin
            w_dividend = r_err[31] ? (~w_ep + 48'd1) : w_ep;
            w_divisor  = pidsc_pkg::DVS_W'(pidsc_pkg::MS_PER_S);
            w_neg      = r_err[31];
        end else if (r_first) begin
            w_dividend = pidsc_pkg::DIV_W'(pidsc_pkg::FIRST_DERIV_NUM);
            w_divisor  = w_per;
            w_neg      = (r_err <= 32'sd0);
        end else begin
            w_dividend = pidsc_pkg::DIV_W'(w_d1000_mag);
            w_divisor  = w_per;
            w_neg      = w_diff[32];
        end
    end

    pidsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_qs = r_neg ? -signed'({2'b00, w_quo}) : signed'({2'b00, w_quo});

    assign w_u    = sat32(r_sum);
    assign w_limp = signed'({1'b0, r_limit});
    assign w_limn = -w_limp;
    assign w_s    = (w_u > w_limp) ? w_limp : ((w_u < w_limn) ? w_limn : w_u);
    assign w_rev  = (w_s != w_u) && (r_err[31] == w_u[31]);
    assign w_s2   = w_rev ? sat32(50'(w_s) - 50'(r_kii) + 50'(w_fl)) : w_s;
    assign w_minp = signed'({1'b0, r_min_mag});

    always_comb begin
        if ((w_s2 > 32'sd0) && (w_s2 < w_minp)) begin
            w_drive = w_minp;
        end else if ((w_s2 < 32'sd0) && (w_s2 > -w_minp)) begin
            w_drive = -w_minp;
        end else begin
            w_drive = w_s2;
        end
    end

    assign w_emag = r_err[31] ? (~r_err + 32'd1) : r_err;
    assign w_keep = (w_emag > {1'b0, r_settle});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= '0;
            r_gain_integ <= '0;
            r_gain_deriv <= '0;
            r_period     <= pidsc_pkg::PERIOD_RESET;
            r_min_mag    <= '0;
            r_settle     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                pidsc_pkg::REG_GAIN_PROP:  r_gain_prop  <= i_cfg_data;
                pidsc_pkg::REG_GAIN_INTEG: r_gain_integ <= i_cfg_data;
                pidsc_pkg::REG_GAIN_DERIV: r_gain_deriv <= i_cfg_data;
                pidsc_pkg::REG_PERIOD_MS:  r_period     <= i_cfg_data[15:0];
                pidsc_pkg::REG_MIN_MAG:    r_min_mag    <= i_cfg_data[30:0];
                pidsc_pkg::REG_SETTLE:     r_settle     <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_last      <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_state) begin
                r_acc   <= '0;
                r_last  <= '0;
                r_first <= 1'b1;
            end else if (i_cmd.finish) begin
                r_acc   <= w_rev ? r_acc : r_integ;
                r_last  <= r_err;
                r_first <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_err   <= i_err_value;
            r_limit <= i_out_limit;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_start) begin
            r_neg <= w_neg;
        end
        if (i_cmd.take_integ) begin
            r_integ <= sat32(50'(r_acc) + w_qs);
        end
        if (i_cmd.take_deriv) begin
            r_deriv <= sat32(w_qs);
        end
        if (i_cmd.sum_init) begin
            r_sum <= 50'(w_fl);
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + 50'(w_fl);
        end
        if (i_cmd.save_kii) begin
            r_kii <= w_fl;
        end
        if (i_cmd.finish) begin
            r_drive <= w_drive;
            r_keep  <= w_keep;
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.out_busy = r_out_valid && !i_res_ready;

    assign o_res_valid  = r_out_valid;
    assign o_drive      = r_drive;
    assign o_keep_going = r_keep;

    `PIDSC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.finish, !(r_out_valid && !i_res_ready))
    `PIDSC_ASSERT_IMP(a_div_idle_on_start, i_clk, i_rst_n, i_cmd.div_start, !w_div_busy)
    `PIDSC_ASSERT_NXT(a_finish_shows_result, i_clk, i_rst_n, i_cmd.finish, r_out_valid)

endmodule

[hw/rtl/pid_speed_controller.sv]
// Top level of the PID speed controller with integral clamping
//
// Channels: i_step takes one item per control step (req_type 0) or a state
// clear (req_type 1); o_result returns drive and keep_going for each control
// step, nothing for a clear; i_cfg writes the six setup registers by index
// and is always ready, writes belong in idle periods.
// Step: a result is registered in the output register as its step finishes,
// and the block is ready for the next item from then on. A clear item is
// taken in idle and leaves the block ready. The step time comes from two
// passes through the divider, which retires 4 quotient bits a cycle over a
// 48-bit dividend, plus the five uses of the shared 32x32 multiplier.
// Reset: gains, bias and band go to zero, the period to 10 ms, the integral
// and previous error to zero and the first-sample flag is set.
// Stall: a result waits in the output register while o_result.ready is low;
// the next step is accepted and computed meanwhile and holds only at its
// last cycle until the register frees.
module pid_speed_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pidsc_step_if.sink          i_step,
    pidsc_result_if.source      o_result,
    pidsc_cfg_if.sink           i_cfg
);

    pidsc_pkg::t_cmd w_cmd;
    pidsc_pkg::t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    pidsc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_valid (i_step.valid),
        .i_step_clear (i_step.req_type),
        .o_step_ready (i_step.ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    pidsc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_addr   (i_cfg.addr),
        .i_cfg_data   (i_cfg.data),
        .i_err_value  (i_step.err_value),
        .i_out_limit  (i_step.out_limit),
        .o_res_valid  (o_result.valid),
        .i_res_ready  (o_result.ready),
        .o_drive      (o_result.drive),
        .o_keep_going (o_result.keep_going)
    );

endmodule

[tb/sv/pidsc_tb_pkg.sv]
// Request kinds shared by the speed controller testbench modules
package pidsc_tb_pkg;

    typedef enum logic {
        REQ_STEP  = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req_kind;

endpackage

[tb/sv/pidsc_checker.sv]
// Scoreboard for the speed controller: predicts each drive item and compares results
module pidsc_checker
    import pidsc_pkg::*;
    import pidsc_tb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    pidsc_step_if   step,
    pidsc_result_if result,
    pidsc_cfg_if    cfg,
    output int      o_fail_count,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [ERR_W-1:0] drive;
        logic                    keep_going;
    } t_drive;

    longint                kp, ki, kd;
    logic [PERIOD_W-1:0]   period;
    longint                min_drive, settle;
    longint                integ_sum, prev_err;
    logic                  first_pass;
    t_drive                due_drives[$];
    int                    fail_count = 0;

    function automatic longint sat32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic t_drive control_law(input longint e, input longint lim);
        longint per, integ, deriv, u, s, mag;
        t_drive r;
        per   = (period == 0) ? 64'sd1 : longint'(period);
        integ = sat32(integ_sum + (e * per) / 1000);
        if (first_pass) begin
            deriv = 64'sd65536000 / per;
            if (e <= 0) deriv = -deriv;
        end else begin
            deriv = sat32(((e - prev_err) * 1000) / per);
        end
        u = sat32(qmul(kp, e) + qmul(ki, integ) + qmul(kd, deriv));
        s = u;
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        // drop the integral update while saturated in the direction of the error
        if (s != u && ((e < 0) == (u < 0))) begin
            s     = sat32(s - qmul(ki, integ) + qmul(ki, integ_sum));
            integ = integ_sum;
        end
        integ_sum  = integ;
        prev_err   = e;
        first_pass = 1'b0;
        if (s > 0 && s < min_drive) s = min_drive;
        if (s < 0 && s > -min_drive) s = -min_drive;
        mag          = (e < 0) ? -e : e;
        r.drive      = s[ERR_W-1:0];
        r.keep_going = (mag > settle);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_drive want;
        if (!i_rst_n) begin
            kp         = 0;
            ki         = 0;
            kd         = 0;
            period     = PERIOD_RESET;
            min_drive  = 0;
            settle     = 0;
            integ_sum  = 0;
            prev_err   = 0;
            first_pass = 1'b1;
            due_drives.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    REG_GAIN_PROP:  kp = $signed(cfg.data);
                    REG_GAIN_INTEG: ki = $signed(cfg.data);
                    REG_GAIN_DERIV: kd = $signed(cfg.data);
                    REG_PERIOD_MS:  period = cfg.data[PERIOD_W-1:0];
                    REG_MIN_MAG:    min_drive = longint'(cfg.data[LIM_W-1:0]);
                    REG_SETTLE:     settle = longint'(cfg.data[LIM_W-1:0]);
                    default: ;
                endcase
            end
            if (step.valid && step.ready) begin
                if (step.req_type == REQ_CLEAR) begin
                    integ_sum  = 0;
                    prev_err   = 0;
                    first_pass = 1'b1;
                end else begin
                    due_drives.push_back(control_law(longint'(step.err_value),
                                                     longint'(step.out_limit)));
                end
            end
            if (result.valid && result.ready) begin
                if (due_drives.size() == 0) begin
                    $error("drive: expected no item, actual %0d", result.drive);
                    fail_count++;
                end else begin
                    want = due_drives.pop_front();
                    if (result.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d", want.drive, result.drive);
                        fail_count++;
                    end
                    if (result.keep_going !== want.keep_going) begin
                        $error("keep_going: expected %0b, actual %0b",
                               want.keep_going, result.keep_going);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= due_drives.size();
        o_fail_count <= fail_count;
    end

endmodule

[tb/sv/tb.sv]
// Testbench top for the speed controller: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidsc_pkg::*;
    import pidsc_tb_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 116;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   burst_left;
    logic signed [ERR_W-1:0] walk;

    pidsc_step_if   step_ch();
    pidsc_result_if result_ch();
    pidsc_cfg_if    cfg_ch();

    pid_speed_controller dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    pidsc_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .step         (step_ch),
        .result       (result_ch),
        .cfg          (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: segments of always-ready, light stalls, coin flips and long stalls
    initial begin
        int   seg_left;
        int   mode;
        int   hold;
        logic stalled;
        seg_left = 0;
        mode     = 0;
        hold     = 0;
        stalled  = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(50, 400);
            end
            seg_left--;
            case (mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                2: result_ch.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (hold == 0) begin
                        stalled = !stalled;
                        hold    = stalled ? $urandom_range(1, 60) : $urandom_range(1, 5);
                    end
                    hold--;
                    result_ch.ready <= !stalled;
                end
            endcase
        end
    end

    task automatic send_item(input t_req_kind kind, input logic signed [ERR_W-1:0] err,
                             input logic [LIM_W-1:0] lim);
        step_ch.valid     <= 1'b1;
        step_ch.req_type  <= kind;
        step_ch.err_value <= err;
        step_ch.out_limit <= lim;
        do @(posedge i_clk); while (!step_ch.ready);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            step_ch.valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 45 : 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic quiesce();
        step_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] kp_v, ki_v, kd_v, per_v,
                             mag_v, band_v);
        logic [CFG_DATA_W-1:0] vals [8];
        quiesce();
        vals[REG_GAIN_PROP]  = kp_v;
        vals[REG_GAIN_INTEG] = ki_v;
        vals[REG_GAIN_DERIV] = kd_v;
        vals[REG_PERIOD_MS]  = per_v;
        vals[REG_MIN_MAG]    = mag_v;
        vals[REG_SETTLE]     = band_v;
        vals[REG_SPARE_LO]   = $urandom;
        vals[REG_SPARE_HI]   = $urandom;
        for (int i = 0; i < 8; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr  <= CFG_ADDR_W'(i);
            cfg_ch.data  <= vals[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return '0;
            1, 2:    return $urandom_range(0, 32'h30000);
            3:       return -$urandom_range(0, 32'h30000);
            4:       return $urandom;
            5:       return 32'h7fff_ffff;
            default: return 32'h8000_0000;
        endcase
    endfunction

    task automatic random_items(input int count);
        logic signed [ERR_W-1:0] err;
        logic [LIM_W-1:0]        lim;
        int                      delta;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    delta = int'($urandom_range(0, 32'h4000)) - 32'sh2000;
                    walk  = walk + delta;
                    err   = walk;
                end
                7, 8: begin
                    err  = int'($urandom_range(0, 32'h80000)) - 32'sh40000;
                    walk = err;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       err = $urandom;
                        1:       err = 32'sh7fff_ffff;
                        2:       err = 32'sh8000_0000;
                        3:       err = '0;
                        4:       err = 32'sd1;
                        default: err = -32'sd1;
                    endcase
                end
            endcase
            case ($urandom_range(0, 7))
                0:       lim = '0;
                1:       lim = 31'h7fff_ffff;
                2:       lim = LIM_W'($urandom);
                default: lim = LIM_W'($urandom_range(0, 32'h30000));
            endcase
            if ($urandom_range(0, 24) == 0) begin
                send_item(REQ_CLEAR, $urandom, LIM_W'($urandom));
                walk = int'($urandom_range(0, 32'h20000)) - 32'sh10000;
            end else begin
                send_item(REQ_STEP, err, lim);
            end
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] per_v;
        logic [CFG_DATA_W-1:0] mag_v;
        logic [CFG_DATA_W-1:0] band_v;
        i_rst_n           <= 1'b0;
        step_ch.valid     <= 1'b0;
        step_ch.req_type  <= REQ_STEP;
        step_ch.err_value <= '0;
        step_ch.out_limit <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.addr       <= REG_GAIN_PROP;
        cfg_ch.data       <= '0;
        burst_left = $urandom_range(1, 10);
        walk       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers
        send_item(REQ_STEP, 32'sh0001_0000, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh0, 31'h7fff_ffff);

        configure(32'h0001_0000, 32'h0000_8000, 32'h0000_0100,
                  {16'($urandom_range(0, 16'hffff)), 16'd10},
                  {1'($urandom_range(0, 1)), 31'h0000_1000}, 32'h0000_8000);
        send_item(REQ_CLEAR, 32'sh7fff_ffff, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh0, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh7fff_ffff, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh8000_0000, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh0000_1000, 31'h10);
        send_item(REQ_STEP, 32'sh0000_1000, 31'h10);
        send_item(REQ_STEP, -32'sh0000_1000, 31'h10);
        send_item(REQ_STEP, 32'sd1, 31'h7fff_ffff);
        send_item(REQ_STEP, -32'sd1, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sd5, 31'h0);
        send_item(REQ_CLEAR, 32'sh8000_0000, 31'h0);
        send_item(REQ_STEP, -32'sh0002_0000, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh7fff_ffff, 31'h3fff_ffff);

        // zero period and extreme gains
        configure(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000,
                  32'hffff_ffff, 32'hffff_ffff);
        send_item(REQ_CLEAR, 32'sh0, 31'h0);
        send_item(REQ_STEP, 32'sh7fff_ffff, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh8000_0000, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh0, 31'h7fff_ffff);
        send_item(REQ_STEP, -32'sd5, 31'd12345);

        configure(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_ffff,
                  32'h0, 32'h0);
        send_item(REQ_CLEAR, 32'sh0, 31'h0);
        send_item(REQ_STEP, 32'sh1234_5678, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh8000_0000, 31'h1000);
        send_item(REQ_STEP, 32'sh7fff_ffff, 31'h7fff_ffff);
        send_item(REQ_STEP, 32'sh0, 31'h7fff_ffff);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       per_v = {16'($urandom_range(0, 16'hffff)), 16'd0};
                1:       per_v = {16'($urandom_range(0, 16'hffff)), 16'd1};
                2:       per_v = {16'($urandom_range(0, 16'hffff)), 16'hffff};
                3, 4:    per_v = {16'($urandom_range(0, 16'hffff)),
                                  16'($urandom_range(1, 100))};
                default: per_v = $urandom;
            endcase
            case ($urandom_range(0, 2))
                0:       mag_v = {1'($urandom_range(0, 1)), 31'h0};
                1:       mag_v = $urandom_range(0, 32'h2000);
                default: mag_v = $urandom;
            endcase
            case ($urandom_range(0, 2))
                0:       band_v = '0;
                1:       band_v = $urandom_range(0, 32'h40000);
                default: band_v = $urandom;
            endcase
            configure(pick_gain(), pick_gain(), pick_gain(), per_v, mag_v, band_v);
            random_items(PHASE_ITEMS);
        end

        quiesce();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
